// ===== design/polyline_longest_segment_split_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef POLYLINE_LONGEST_SEGMENT_SPLIT_ASSERT_SVH
`define POLYLINE_LONGEST_SEGMENT_SPLIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PLSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PLSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/plss_pkg.sv =====
`default_nettype none
package plss_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 24;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CFG_W      = 7;
  localparam int TGT_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int PT_W       = 3 * COORD_BITS;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int SUM_W      = SQ_W + 2;

  localparam logic [CFG_W-1:0] TARGET_RESET = CFG_W'(64);

  typedef logic [2:0][COORD_BITS-1:0] pt_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_SHIFT,
    ST_SHIFT_END,
    ST_PUT_MID,
    ST_EMIT_FIRST,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load_en;
    logic scan_start;
    logic scan_step;
    logic shift_start;
    logic shift_step;
    logic put_mid;
    logic emit_start;
    logic emit_step;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic refine_go;
    logic ptr_at_end;
    logic pipe_busy;
    logic found;
    logic shift_done;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/plss_ram.sv =====
`default_nettype none
module plss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output      logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/plss_ctrl.sv =====
`default_nettype none
module plss_ctrl import plss_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_last_i,
  output      logic in_stall_o,
  output      logic out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output      cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o    = 1'b0;
        cmd_o.load_en = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.refine_go) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_EMIT_FIRST;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.ptr_at_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          if (sts_i.found) begin
            cmd_o.shift_start = 1'b1;
            state_d           = ST_SHIFT;
          end else begin
            state_d = ST_EMIT_FIRST;
          end
        end
      end
      ST_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.shift_done) begin
          state_d = ST_SHIFT_END;
        end
      end
      ST_SHIFT_END: begin
        state_d = ST_PUT_MID;
      end
      ST_PUT_MID: begin
        cmd_o.put_mid = 1'b1;
        state_d       = ST_CHECK;
      end
      ST_EMIT_FIRST: begin
        cmd_o.emit_start = 1'b1;
        state_d          = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.ptr_at_end) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            cmd_o.emit_step = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/plss_datapath.sv =====
`default_nettype none
module plss_datapath import plss_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_t                   cmd_i,
  output      sts_t                   sts_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i,
  input  wire pt_t                    pt_i,
  output      pt_t                    pt_o
);

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] t;
    t = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    if (t < 0) begin
      t = -t;
    end
    return t[COORD_BITS-1:0];
  endfunction

  // Floor of the half sum: arithmetic shift of the exact sum.
  function automatic logic [COORD_BITS-1:0] half_sum(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] s;
    s = $signed({a[COORD_BITS-1], a}) + $signed({b[COORD_BITS-1], b});
    return s[COORD_BITS:1];
  endfunction

  logic [CFG_W-1:0] target_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] cnt_m1;
  logic [TGT_W-1:0] tgt_sat;

  // RAM ports
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  pt_t              wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  pt_t              rd_data;

  // Shift write-back
  logic             pend_v_q;
  logic [IDX_W-1:0] pend_addr_q;

  // Scan pipeline
  logic                            rv_q;
  logic [IDX_W-1:0]                ridx_q;
  logic                            have_prev_q;
  pt_t                             prev_q;
  logic                            v1_q, v2_q;
  logic [IDX_W-1:0]                idx1_q, idx2_q;
  logic [2:0][COORD_BITS-1:0]      d1_q;
  pt_t                             mid1_q, mid2_q;
  logic [2:0][SQ_W-1:0]            sq2_q;
  logic [SUM_W-1:0]                sum2;
  logic [SUM_W-1:0]                best_q;
  logic [IDX_W-1:0]                best_idx_q;
  pt_t                             mid_q;
  logic                            found_q;

  assign cnt_m1  = count_q - CNT_W'(1);
  assign tgt_sat = (TGT_W'(target_q) > TGT_W'(MAX_POINTS)) ? TGT_W'(MAX_POINTS)
                                                           : TGT_W'(target_q);

  assign sts_o.refine_go  = (TGT_W'(count_q) < tgt_sat) && (count_q >= CNT_W'(2));
  assign sts_o.ptr_at_end = (CNT_W'(ptr_q) == cnt_m1);
  assign sts_o.pipe_busy  = rv_q | v1_q | v2_q;
  assign sts_o.found      = found_q;
  assign sts_o.shift_done = (ptr_q == best_idx_q + IDX_W'(1));

  always_comb begin
    count_d = count_q;
    if (cmd_i.load_en && (count_q < CNT_W'(MAX_POINTS))) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.put_mid) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.clear) begin
      count_d = '0;
    end
  end

  always_comb begin
    ptr_d   = ptr_q;
    rd_en   = 1'b0;
    rd_addr = ptr_q;
    if (cmd_i.scan_start || cmd_i.emit_start) begin
      ptr_d = '0;
    end
    if (cmd_i.emit_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end
    if (cmd_i.scan_step) begin
      rd_en = 1'b1;
      ptr_d = ptr_q + IDX_W'(1);
    end
    if (cmd_i.shift_start) begin
      ptr_d = cnt_m1[IDX_W-1:0];
    end
    if (cmd_i.shift_step) begin
      rd_en = 1'b1;
      ptr_d = ptr_q - IDX_W'(1);
    end
    if (cmd_i.emit_step) begin
      rd_en   = 1'b1;
      rd_addr = ptr_q + IDX_W'(1);
      ptr_d   = ptr_q + IDX_W'(1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IDX_W-1:0];
    wr_data = pt_i;
    if (cmd_i.load_en && (count_q < CNT_W'(MAX_POINTS))) begin
      wr_en = 1'b1;
    end else if (pend_v_q) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr_q;
      wr_data = rd_data;
    end else if (cmd_i.put_mid) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_q + IDX_W'(1);
      wr_data = mid_q;
    end
  end

  plss_ram #(
    .WIDTH(PT_W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign pt_o = rd_data;
  assign sum2 = SUM_W'(sq2_q[0]) + SUM_W'(sq2_q[1]) + SUM_W'(sq2_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= TARGET_RESET;
      count_q     <= '0;
      ptr_q       <= '0;
      pend_v_q    <= 1'b0;
      rv_q        <= 1'b0;
      have_prev_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_data_i;
      end
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      pend_v_q <= cmd_i.shift_step;
      rv_q     <= cmd_i.scan_step;
      v1_q     <= rv_q && have_prev_q;
      v2_q     <= v1_q;
      if (cmd_i.scan_start) begin
        have_prev_q <= 1'b0;
        found_q     <= 1'b0;
      end else begin
        if (rv_q) begin
          have_prev_q <= 1'b1;
        end
        if (v2_q && (sum2 > best_q)) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_step) begin
      pend_addr_q <= ptr_q + IDX_W'(1);
    end
    if (cmd_i.scan_step) begin
      ridx_q <= ptr_q;
    end
    if (rv_q) begin
      prev_q <= rd_data;
      idx1_q <= ridx_q - IDX_W'(1);
      for (int k = 0; k < 3; k++) begin
        d1_q[k]   <= abs_diff(prev_q[k], rd_data[k]);
        mid1_q[k] <= half_sum(prev_q[k], rd_data[k]);
      end
    end
    idx2_q <= idx1_q;
    mid2_q <= mid1_q;
    for (int k = 0; k < 3; k++) begin
      sq2_q[k] <= d1_q[k] * d1_q[k];
    end
    if (cmd_i.scan_start) begin
      best_q <= '0;
    end else if (v2_q && (sum2 > best_q)) begin
      best_q     <= sum2;
      best_idx_q <= idx2_q;
      mid_q      <= mid2_q;
    end
  end

endmodule
`default_nettype wire

// ===== design/polyline_longest_segment_split.sv =====
// Loading: one word per cycle while the input is not stalled; the word
// marked last closes the polyline. Each inserted point takes a scan of
// the N stored points, a shift of the points after the chosen segment k
// and a write of the midpoint. Emission: one word per cycle while the
// output is not stalled. Reset clears the point count and the control
// state and sets target_count to 64; the point store itself is not cleared.
`default_nettype none
module polyline_longest_segment_split import plss_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration: target point count.
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [CFG_W-1:0]             target_count_i,
  // Point input.
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic signed [COORD_BITS-1:0] coord_x_i,
  input  wire logic signed [COORD_BITS-1:0] coord_y_i,
  input  wire logic signed [COORD_BITS-1:0] coord_z_i,
  input  wire logic                         last_in_i,
  // Refined point output.
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic signed [COORD_BITS-1:0] out_x_o,
  output      logic signed [COORD_BITS-1:0] out_y_o,
  output      logic signed [COORD_BITS-1:0] out_z_o,
  output      logic                         last_out_o
);

  // The controller sequences loading, scanning for the longest segment,
  // opening a gap in the store and writing the midpoint, and finally the
  // emission of every stored point. The datapath holds the store, the
  // counters and the three-stage squared-length pipeline.
  cmd_t cmd;
  sts_t sts;
  pt_t  pt_in;
  pt_t  pt_out;

  // The register may be written at any time; it is sampled at the start of
  // every refinement pass, so it should only change while the block is idle.
  assign cfg_ready_o = 1'b1;

  assign pt_in = {coord_z_i, coord_y_i, coord_x_i};

  plss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (last_in_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plss_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .cfg_we_i  (cfg_valid_i),
    .cfg_data_i(target_count_i),
    .pt_i      (pt_in),
    .pt_o      (pt_out)
  );

  // The output word is the registered read data of the store, which holds
  // still while no new read is issued, so a stalled word does not change.
  assign out_x_o    = pt_out[0];
  assign out_y_o    = pt_out[1];
  assign out_z_o    = pt_out[2];
  assign last_out_o = sts.ptr_at_end;

endmodule
`default_nettype wire

// ===== design/plss_checker.sv =====
`default_nettype none
`include "polyline_longest_segment_split_assert.svh"
module plss_checker import plss_pkg::*; (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         last_in_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic signed [COORD_BITS-1:0] out_x_o,
  input wire logic signed [COORD_BITS-1:0] out_y_o,
  input wire logic signed [COORD_BITS-1:0] out_z_o,
  input wire logic                         last_out_o
);

  logic                  in_take;
  logic                  out_take;
  logic                  out_hold;
  logic                  idle_load;
  logic [3*COORD_BITS:0] out_word;

  assign in_take   = in_valid_i && !in_stall_o;
  assign out_take  = out_valid_o && !out_stall_i;
  assign out_hold  = out_valid_o && out_stall_i;
  assign idle_load = !out_valid_o && !in_stall_o;
  assign out_word  = {last_out_o, out_z_o, out_y_o, out_x_o};

  // A stalled word holds.
  `PLSS_ASSERT_NXT(a_out_hold, out_hold, out_valid_o && $stable(out_word), "stalled word changed")

  // Input and output phases never overlap.
  `PLSS_ASSERT_IMP(a_no_overlap, out_valid_o, in_stall_o, "input open while emitting")

  // A closing word ends the load phase.
  `PLSS_ASSERT_NXT(a_close_load, in_take && last_in_i, in_stall_o, "input open after last word")

  // The final word ends the emission.
  `PLSS_ASSERT_NXT(a_end_emit, out_take && last_out_o, idle_load, "emission did not end")

endmodule

bind polyline_longest_segment_split plss_checker u_plss_checker (.*);
`default_nettype wire

// ===== sim/polyline_longest_segment_split_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module polyline_longest_segment_split_tb;
  import plss_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int EXP_DEPTH      = 256;

  // A refined point as it is expected on the output channel.
  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic                         last;
  } point_word_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_W-1:0]             target_count_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic signed [COORD_BITS-1:0] coord_x_i = '0;
  logic signed [COORD_BITS-1:0] coord_y_i = '0;
  logic signed [COORD_BITS-1:0] coord_z_i = '0;
  logic                         last_in_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b1;
  logic signed [COORD_BITS-1:0] out_x_o;
  logic signed [COORD_BITS-1:0] out_y_o;
  logic signed [COORD_BITS-1:0] out_z_o;
  logic                         last_out_o;

  polyline_longest_segment_split DUT (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .target_count_i,
    .in_valid_i, .in_stall_o, .coord_x_i, .coord_y_i, .coord_z_i, .last_in_i,
    .out_valid_o, .out_stall_i, .out_x_o, .out_y_o, .out_z_o, .last_out_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: our own copy of the store, the count and the register.
  logic signed [COORD_BITS-1:0] poly_x[MAX_POINTS];
  logic signed [COORD_BITS-1:0] poly_y[MAX_POINTS];
  logic signed [COORD_BITS-1:0] poly_z[MAX_POINTS];
  int unsigned                  poly_count;
  int unsigned                  target_setting;

  // Expected words, kept in a ring with free-running write and read counts.
  point_word_t exp_fifo[EXP_DEPTH];
  int unsigned exp_wr;
  int unsigned exp_rd;
  int          error_count;
  int          words_sent;
  int          words_checked;
  int          polylines_sent;
  int          idle_cycles;
  bit          hold_receiver;

  function automatic int unsigned exp_level();
    return exp_wr - exp_rd;
  endfunction

  // Squared segment length, exact in 64 bits for 24-bit coordinates.
  function automatic logic [63:0] seg_len_sq(int unsigned i);
    logic signed [63:0] dx, dy, dz;
    dx = poly_x[i + 1] - poly_x[i];
    dy = poly_y[i + 1] - poly_y[i];
    dz = poly_z[i + 1] - poly_z[i];
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Floor of the half sum: an arithmetic shift of the widened sum.
  function automatic logic signed [COORD_BITS-1:0] mid_coord(
      logic signed [COORD_BITS-1:0] a, logic signed [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] s;
    s = (COORD_BITS+1)'(a) + (COORD_BITS+1)'(b);
    return COORD_BITS'(s >>> 1);
  endfunction

  // Stores one point and, on the last one, refines and queues the whole polyline.
  task automatic predict_polyline_word(logic signed [COORD_BITS-1:0] x,
      logic signed [COORD_BITS-1:0] y, logic signed [COORD_BITS-1:0] z, logic last);
    int unsigned goal, best, i;
    logic [63:0] best_len, len;
    point_word_t w;
    if (poly_count < MAX_POINTS) begin
      poly_x[poly_count] = x;
      poly_y[poly_count] = y;
      poly_z[poly_count] = z;
      poly_count++;
    end
    if (!last) return;
    goal = (target_setting > MAX_POINTS) ? MAX_POINTS : target_setting;
    while (poly_count < goal && poly_count >= 2) begin
      best_len = 0;
      best = 0;
      for (i = 0; i + 1 < poly_count; i++) begin
        len = seg_len_sq(i);
        if (len > best_len) begin
          best_len = len;
          best = i;
        end
      end
      if (best_len == 0) break;
      for (i = poly_count; i > best + 1; i--) begin
        poly_x[i] = poly_x[i - 1];
        poly_y[i] = poly_y[i - 1];
        poly_z[i] = poly_z[i - 1];
      end
      poly_x[best + 1] = mid_coord(poly_x[best], poly_x[best + 2]);
      poly_y[best + 1] = mid_coord(poly_y[best], poly_y[best + 2]);
      poly_z[best + 1] = mid_coord(poly_z[best], poly_z[best + 2]);
      poly_count++;
    end
    for (i = 0; i < poly_count; i++) begin
      w.x = poly_x[i];
      w.y = poly_y[i];
      w.z = poly_z[i];
      w.last = (i + 1 == poly_count);
      exp_fifo[exp_wr % EXP_DEPTH] = w;
      exp_wr++;
    end
    poly_count = 0;
    polylines_sent++;
  endtask

  // Sends one word after a random gap; the prediction is made at acceptance.
  // Valid stays high after acceptance so that a following word can go out
  // back to back; a gap or an idle phase takes it low.
  task automatic send_point(logic signed [COORD_BITS-1:0] x,
      logic signed [COORD_BITS-1:0] y, logic signed [COORD_BITS-1:0] z, logic last);
    int gap;
    gap = $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i  <= x;
    coord_y_i  <= y;
    coord_z_i  <= z;
    last_in_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_polyline_word(x, y, z, last);
    words_sent++;
  endtask

  // Random coordinate: moderate values half the time, else the full range or an extreme.
  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(COORD_BITS-1){1'b0}}};
      1: return {1'b0, {(COORD_BITS-1){1'b1}}};
      2, 3: return COORD_BITS'($urandom);
      default: return COORD_BITS'($signed(COORD_BITS'($urandom_range(0, 4095))) - 2048);
    endcase
  endfunction

  task automatic send_random_polyline(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_point(rand_coord(), rand_coord(), rand_coord(), i + 1 == n);
  endtask

  // Waits until every predicted word has come back, then lets the block settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (exp_level() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes the target register; only called while the block is idle.
  task automatic write_target(int unsigned value);
    cfg_valid_i    <= 1'b1;
    target_count_i <= CFG_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    target_setting = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Extreme coordinates, a single point, a degenerate line, and an unchanged emission.
  task automatic test_directed();
    logic signed [COORD_BITS-1:0] lo, hi;
    lo = {1'b1, {(COORD_BITS-1){1'b0}}};
    hi = {1'b0, {(COORD_BITS-1){1'b1}}};
    write_target(8);
    send_point(lo, lo, lo, 1'b0);
    send_point(hi, hi, hi, 1'b1);
    wait_idle();
    send_point(hi, lo, hi, 1'b1);
    wait_idle();
    send_point(COORD_BITS'(-1), COORD_BITS'(-3), COORD_BITS'(5), 1'b0);
    send_point(COORD_BITS'(-1), COORD_BITS'(-3), COORD_BITS'(5), 1'b0);
    send_point(COORD_BITS'(-1), COORD_BITS'(-3), COORD_BITS'(5), 1'b1);
    wait_idle();
    send_point(COORD_BITS'(-3), COORD_BITS'(0), COORD_BITS'(7), 1'b0);
    send_point(COORD_BITS'(0), COORD_BITS'(-1), COORD_BITS'(0), 1'b0);
    send_point(COORD_BITS'(2), COORD_BITS'(2), COORD_BITS'(2), 1'b1);
    wait_idle();
    write_target(0);
    send_point(COORD_BITS'(10), COORD_BITS'(20), COORD_BITS'(30), 1'b0);
    send_point(COORD_BITS'(-10), COORD_BITS'(0), COORD_BITS'(1), 1'b1);
    wait_idle();
    write_target(127);
    send_point(lo, hi, COORD_BITS'(0), 1'b0);
    send_point(hi, lo, COORD_BITS'(0), 1'b1);
    wait_idle();
  endtask

  // Overfull store: words beyond capacity are dropped but the last mark still counts.
  task automatic test_store_full();
    write_target(3);
    send_random_polyline(MAX_POINTS + 3);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch so that the block backs up its input.
  task automatic test_back_pressure();
    write_target(20);
    hold_receiver = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_receiver = 1'b0;
      end
      begin
        send_random_polyline(4);
        send_random_polyline(3);
      end
    join
    wait_idle();
  endtask

  // Random polylines, mostly short, under several target settings.
  task automatic test_random();
    int unsigned settings[6] = '{2, 5, 12, 64, 1, 33};
    int unsigned sent_before;
    foreach (settings[s]) begin
      write_target(settings[s]);
      sent_before = words_sent;
      while (words_sent - sent_before < 35)
        send_random_polyline($urandom_range(0, 9) == 0 ? $urandom_range(10, 64)
                                                       : $urandom_range(1, 6));
      wait_idle();
    end
  endtask

  // Receiver: draws a stall length per word, or holds off while the pressure test runs.
  initial begin
    int wait_len;
    @(posedge rst_ni);
    forever begin
      wait_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (wait_len != 0 || hold_receiver) begin
        out_stall_i <= 1'b1;
        repeat (wait_len) @(posedge clk_i);
        while (hold_receiver) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Checker: each accepted word is compared with the oldest prediction.
  always @(posedge clk_i) begin
    point_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (exp_level() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d z=%0d last=%0b", $time,
                 out_x_o, out_y_o, out_z_o, last_out_o);
        error_count++;
      end else begin
        w = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_x_o !== w.x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, w.x, out_x_o);
          error_count++;
        end
        if (out_y_o !== w.y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, w.y, out_y_o);
          error_count++;
        end
        if (out_z_o !== w.z) begin
          $display("%0t: out_z expected %0d actual %0d", $time, w.z, out_z_o);
          error_count++;
        end
        if (last_out_o !== w.last) begin
          $display("%0t: last_out expected %0b actual %0b", $time, w.last, last_out_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on any of the three channels.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d words outstanding", $time,
               exp_level());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    error_count    = 0;
    words_sent     = 0;
    words_checked  = 0;
    polylines_sent = 0;
    idle_cycles    = 0;
    poly_count     = 0;
    exp_wr         = 0;
    exp_rd         = 0;
    target_setting = TARGET_RESET;
    hold_receiver  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_store_full();
    test_back_pressure();
    test_random();
    if (exp_level() != 0) begin
      $display("%0t: %0d predicted words never arrived", $time, exp_level());
      error_count++;
    end
    $display("Sent %0d points in %0d polylines, checked %0d refined points.",
             words_sent, polylines_sent, words_checked);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/plss_pkg.sv
design/plss_ram.sv
design/plss_ctrl.sv
design/plss_datapath.sv
design/polyline_longest_segment_split.sv
design/plss_checker.sv
sim/polyline_longest_segment_split_tb.sv
